>>> hw/rtl/smf_pkg.sv
// shared types and codes for the sliding window median filter
// no dependencies; every other file of the block imports this package
package smf_pkg;

   localparam int SAMPLE_W = 16;
   localparam int FILL_W   = 4;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [FILL_W-1:0]          fill_type;

   // item command codes
   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_CLEAR = 1'b1
   } smf_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } smf_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept_add;
      logic accept_clear;
      logic scan;
      logic load_out;
   } smf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
   } smf_stat_type;

endpackage

>>> hw/rtl/smf_req_if.sv
// input channel of the median filter: command and sample
// depends on smf_pkg
interface smf_req_if
   import smf_pkg::*;
();
   logic       valid;
   logic       ready;
   logic       cmd;
   sample_type sample;

   modport source (output valid, output cmd, output sample, input ready);
   modport sink (input valid, input cmd, input sample, output ready);
endinterface

>>> hw/rtl/smf_rsp_if.sv
// result channel of the median filter: median and fill count
// depends on smf_pkg
interface smf_rsp_if
   import smf_pkg::*;
();
   logic       valid;
   logic       ready;
   sample_type median;
   fill_type   fill_count;

   modport source (output valid, output median, output fill_count, input ready);
   modport sink (input valid, input median, input fill_count, output ready);
endinterface

>>> hw/rtl/smf_ctrl.sv
// control state machine of the median filter: handshakes and scan sequencing
// depends on smf_pkg; drives smf_datapath through smf_cmd_type
module smf_ctrl
   import smf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_cmd,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  smf_stat_type stat,
   output smf_cmd_type  cmd
);

   smf_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_free;
   logic          is_clear;

   assign out_free = !out_valid_ff || rsp_ready;
   assign is_clear = (req_cmd == OP_CLEAR);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = is_clear ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready        = 1'b0;
      cmd.accept_add   = 1'b0;
      cmd.accept_clear = 1'b0;
      cmd.scan         = 1'b0;
      cmd.load_out     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready        = 1'b1;
            cmd.accept_add   = req_valid && !is_clear;
            cmd.accept_clear = req_valid && is_clear;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_FINISH: begin
            cmd.load_out = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

   a_clear_to_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.accept_clear |=> state_ff == ST_FINISH)
      else $error("clear item did not go straight to finish");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && stat.scan_last) |=> state_ff == ST_FINISH)
      else $error("scan did not end on its last candidate");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("loaded result not presented");

endmodule

>>> hw/rtl/smf_datapath.sv
// window store, rank counting and median arithmetic of the median filter
// depends on smf_pkg; sequenced by smf_ctrl through smf_cmd_type
module smf_datapath
   import smf_pkg::*;
#(
   parameter int WINDOW = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  smf_cmd_type  cmd,
   input  sample_type   req_sample,
   output smf_stat_type stat,
   output sample_type   rsp_median,
   output fill_type     rsp_fill_count
);

   localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FW = $clog2(WINDOW + 1);

   // entries at or above the fill count are never read, so they need no clearing
   sample_type  store_ff [WINDOW];
   logic [SW-1:0] slot_ff, slot_in;
   logic [FW-1:0] filled_ff, filled_in;
   logic [SW-1:0] cand_ff, cand_in;
   sample_type  lo_ff, hi_ff;
   sample_type  med_ff;
   fill_type    fill_out_ff;

   sample_type    cand_val;
   logic [WINDOW-1:0] lt_vec, le_vec;
   logic [FW-1:0] lt_cnt, le_cnt;
   logic [FW-1:0] k_lo, k_hi;
   logic          hit_lo, hit_hi;
   logic signed [SAMPLE_W:0] pair_sum;
   logic signed [SAMPLE_W:0] pair_half;
   sample_type    med_val;
   logic [FW+FILL_W-1:0] filled_ext;

   always_comb begin
      slot_in   = slot_ff;
      filled_in = filled_ff;
      if (cmd.accept_clear) begin
         slot_in   = '0;
         filled_in = '0;
      end else if (cmd.accept_add) begin
         slot_in = (slot_ff == SW'(WINDOW - 1)) ? '0 : slot_ff + SW'(1);
         if (filled_ff != FW'(WINDOW)) begin
            filled_in = filled_ff + FW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= '0;
         filled_ff <= '0;
      end else begin
         slot_ff   <= slot_in;
         filled_ff <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_add) begin
         store_ff[slot_ff] <= req_sample;
      end
   end

   // rank of the candidate among the filled entries
   assign cand_val = store_ff[cand_ff];

   always_comb begin
      for (int j = 0; j < WINDOW; j++) begin
         lt_vec[j] = (FW'(j) < filled_ff) && (store_ff[j] <  cand_val);
         le_vec[j] = (FW'(j) < filled_ff) && (store_ff[j] <= cand_val);
      end
   end

   assign lt_cnt = FW'($countones(lt_vec));
   assign le_cnt = FW'($countones(le_vec));
   assign k_lo   = (filled_ff - FW'(1)) >> 1;
   assign k_hi   = filled_ff >> 1;
   assign hit_lo = (lt_cnt <= k_lo) && (k_lo < le_cnt);
   assign hit_hi = (lt_cnt <= k_hi) && (k_hi < le_cnt);

   assign stat.scan_last = (FW'(cand_ff) == filled_ff - FW'(1));

   always_comb begin
      cand_in = cand_ff;
      if (cmd.accept_add) begin
         cand_in = '0;
      end else if (cmd.scan && !stat.scan_last) begin
         cand_in = cand_ff + SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= '0;
      end else begin
         cand_ff <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && hit_lo) begin
         lo_ff <= cand_val;
      end
      if (cmd.scan && hit_hi) begin
         hi_ff <= cand_val;
      end
   end

   // even count: (lo + hi + 1) / 2 truncated toward zero
   assign pair_sum  = (SAMPLE_W+1)'(lo_ff) + (SAMPLE_W+1)'(hi_ff) + (SAMPLE_W+1)'(1);
   assign pair_half = pair_sum[SAMPLE_W] ? ((pair_sum + (SAMPLE_W+1)'(1)) >>> 1)
                                         : (pair_sum >>> 1);

   always_comb begin
      if (filled_ff == '0) begin
         med_val = '0;
      end else if (filled_ff[0]) begin
         med_val = hi_ff;
      end else begin
         med_val = pair_half[SAMPLE_W-1:0];
      end
   end

   assign filled_ext = {{FILL_W{1'b0}}, filled_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         med_ff      <= med_val;
         fill_out_ff <= filled_ext[FILL_W-1:0];
      end
   end

   assign rsp_median     = med_ff;
   assign rsp_fill_count = fill_out_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FW'(WINDOW))
      else $error("fill count beyond window");

   a_cand_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> FW'(cand_ff) < filled_ff)
      else $error("candidate outside filled entries");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.accept_clear |=> (filled_ff == '0 && slot_ff == '0))
      else $error("clear left the window non-empty");

endmodule

>>> hw/rtl/sliding_window_median_filter.sv
// sliding window median filter, top level: controller plus datapath
// depends on smf_pkg, smf_req_if, smf_rsp_if, smf_ctrl and smf_datapath
// an add item scans each of its n candidates in turn, n = fill count after the add
// (at most WINDOW), then loads its result into the output register; a clear loads with no scan
// the next item is taken the cycle after the result loads, so a result that waits on
// the output holds off the next item; synchronous reset empties the window
module sliding_window_median_filter
   import smf_pkg::*;
#(
   parameter int WINDOW = 8
) (
   input  logic     clock,
   input  logic     reset,
   smf_req_if.sink  req,
   smf_rsp_if.source rsp
);

   // command and status bundles between the two halves
   smf_cmd_type  cmd;
   smf_stat_type stat;

   // controller: accepts an item only when idle, then scans the window
   // candidates one per cycle and parks the result in the output register
   // as soon as that register is free or being drained
   smf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_cmd   (req.cmd),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: ring store of the last WINDOW samples, fill count,
   // rank counter per candidate and the rounding of the two middle values
   smf_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_sample     (req.sample),
      .stat           (stat),
      .rsp_median     (rsp.median),
      .rsp_fill_count (rsp.fill_count)
   );

endmodule
